@@ src/scrq_pkg.sv @@
// ----------------------------------------------------------------------------
// scrq_pkg
// Types, field widths and codes shared by the serial command retry queue.
// ----------------------------------------------------------------------------
package scrq_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 3;
    localparam int ERR_W  = 8;
    localparam int TXC_W  = 17;

    localparam logic       OP_ENQUEUE    = 1'b0;
    localparam logic       OP_TICK       = 1'b1;
    localparam int         SUCCESS_BIT   = 24;
    localparam int         FAILURE_BIT   = 25;
    localparam logic [1:0] LATENCY_TICKS = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 3'd4;
    localparam logic [ERR_W-1:0]  ERR_MAX  = 8'hff;

    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 112;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [SIZE_W-1:0] size;
        logic              write;
        logic [ADDR_W-1:0] address;
    } t_entry;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] cmd_address;
        logic              cmd_write;
        logic [SIZE_W-1:0] cmd_size;
        logic [DATA_W-1:0] cmd_data;
        logic              fault_no_response;
        logic              fault_not_finished;
        logic              fault_crc;
        logic [DATA_W-1:0] rx_control;
        logic [DATA_W-1:0] rx_data;
    } t_item;

    typedef struct packed {
        logic              enqueue_refused;
        logic [TXC_W-1:0]  tx_control;
        logic [DATA_W-1:0] tx_data;
        logic              done_valid;
        logic              done_failed;
        logic [ADDR_W-1:0] done_address;
        logic [DATA_W-1:0] done_read_data;
        logic              queue_empty;
        logic [ERR_W-1:0]  packet_error_count;
    } t_result;

    function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
        logic [DATA_W-1:0] m;
        case (size)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

@@ src/serial_command_retry_queue.sv @@
// ----------------------------------------------------------------------------
// serial_command_retry_queue
// Bounded retry queue of register commands for a device on a cyclic link.
//
//   channel  dir  handshake                       payload
//   s_axis   in   s_axis_tvalid / s_axis_tready   tuser = op, tdata = fields
//   m_axis   out  m_axis_tvalid / m_axis_tready   tdata = result fields
//
// For each word the accept cycle issues both store reads (send slot and
// head slot); the next cycle computes and writes back.
// Store contents are undefined until written; reset clears pointers, send index, error run and flags only.
// s_axis_tready drops while a word is in work or a result waits untaken.
// One result per input word, held in the output register until taken.
// ----------------------------------------------------------------------------
module serial_command_retry_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [0] op
    input  logic         s_axis_tuser,
    // [15:0] cmd_address, [16] cmd_write, [19:17] cmd_size, [51:20] cmd_data,
    // [52] fault_no_response, [53] fault_not_finished, [54] fault_crc,
    // [86:55] rx_control, [118:87] rx_data, [119] zero
    input  logic [scrq_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] enqueue_refused, [17:1] tx_control, [49:18] tx_data, [50] done_valid,
    // [51] done_failed, [67:52] done_address, [99:68] done_read_data,
    // [100] queue_empty, [108:101] packet_error_count, [111:109] zero
    output logic [scrq_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic              r_busy;
    logic              r_out_valid;
    scrq_pkg::t_item   r_item;
    scrq_pkg::t_result r_out;
    scrq_pkg::t_item   in_item;
    scrq_pkg::t_result res;
    scrq_pkg::t_entry  rd_send, rd_head, wr_entry;
    logic [PW-1:0]     rd_addr_send, rd_addr_head, wr_addr;
    logic              wr_en;
    logic              accept;

    assign s_axis_tready = !r_busy && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_item.op                 = s_axis_tuser;
        in_item.cmd_address        = s_axis_tdata[15:0];
        in_item.cmd_write          = s_axis_tdata[16];
        in_item.cmd_size           = s_axis_tdata[19:17];
        in_item.cmd_data           = s_axis_tdata[51:20];
        in_item.fault_no_response  = s_axis_tdata[52];
        in_item.fault_not_finished = s_axis_tdata[53];
        in_item.fault_crc          = s_axis_tdata[54];
        in_item.rx_control         = s_axis_tdata[86:55];
        in_item.rx_data            = s_axis_tdata[118:87];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= in_item;
        end
        if (r_busy) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= accept;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    scrq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (PW)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_entry  (wr_entry),
        .i_rd_addr_a (rd_addr_send),
        .i_rd_addr_b (rd_addr_head),
        .o_rd_a      (rd_send),
        .o_rd_b      (rd_head)
    );

    scrq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (r_busy),
        .i_item         (r_item),
        .i_rd_send      (rd_send),
        .i_rd_head      (rd_head),
        .o_rd_addr_send (rd_addr_send),
        .o_rd_addr_head (rd_addr_head),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_entry     (wr_entry),
        .o_res          (res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000,
                            r_out.packet_error_count,
                            r_out.queue_empty,
                            r_out.done_read_data,
                            r_out.done_address,
                            r_out.done_failed,
                            r_out.done_valid,
                            r_out.tx_data,
                            r_out.tx_control,
                            r_out.enqueue_refused};

endmodule

@@ src/scrq_store.sv @@
// ----------------------------------------------------------------------------
// scrq_store
// Command store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module scrq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  scrq_pkg::t_entry i_wr_entry,
    input  logic [AW-1:0]   i_rd_addr_a,
    input  logic [AW-1:0]   i_rd_addr_b,
    output scrq_pkg::t_entry o_rd_a,
    output scrq_pkg::t_entry o_rd_b
);

    scrq_pkg::t_entry mem [DEPTH];
    scrq_pkg::t_entry r_rd_a;
    scrq_pkg::t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_entry;
        end
        r_rd_a <= mem[i_rd_addr_a];
        r_rd_b <= mem[i_rd_addr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

@@ src/scrq_engine.sv @@
// ----------------------------------------------------------------------------
// scrq_engine
// Queue pointers, send index and error run; store reads and enqueue writes.
// ----------------------------------------------------------------------------
module scrq_engine #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  scrq_pkg::t_item   i_item,
    input  scrq_pkg::t_entry  i_rd_send,
    input  scrq_pkg::t_entry  i_rd_head,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_rd_addr_send,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_rd_addr_head,
    output logic              o_wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_wr_addr,
    output scrq_pkg::t_entry  o_wr_entry,
    output scrq_pkg::t_result o_res
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [PW-1:0]              r_head, n_head;
    logic [CW-1:0]              r_count, n_count;
    logic [1:0]                 r_sidx, n_sidx;
    logic [scrq_pkg::ERR_W-1:0] r_err, n_err;

    logic [PW:0]   send_sum, tail_sum;
    logic [PW-1:0] send_slot, tail_slot, head_next;
    logic [scrq_pkg::SIZE_W-1:0] sat_size;
    logic fault, match, ok, bad;

    assign send_sum  = {1'b0, r_head} + (PW+1)'(r_sidx);
    assign tail_sum  = {1'b0, r_head} + (PW+1)'(r_count);
    assign send_slot = (send_sum >= (PW+1)'(QUEUE_DEPTH))
                       ? PW'(send_sum - (PW+1)'(QUEUE_DEPTH)) : send_sum[PW-1:0];
    assign tail_slot = (tail_sum >= (PW+1)'(QUEUE_DEPTH))
                       ? PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : tail_sum[PW-1:0];
    assign head_next = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + PW'(1);

    assign o_rd_addr_send = send_slot;
    assign o_rd_addr_head = r_head;
    assign o_wr_addr      = tail_slot;

    assign sat_size = (i_item.cmd_size > scrq_pkg::SIZE_MAX) ? scrq_pkg::SIZE_MAX
                                                             : i_item.cmd_size;
    assign fault = i_item.fault_no_response | i_item.fault_not_finished | i_item.fault_crc;
    assign match = i_item.rx_control[scrq_pkg::ADDR_W-1:0] == i_rd_head.address;
    assign ok    = i_item.rx_control[scrq_pkg::SUCCESS_BIT];
    assign bad   = i_item.rx_control[scrq_pkg::FAILURE_BIT];

    always_comb begin
        o_wr_entry.address = i_item.cmd_address;
        o_wr_entry.write   = i_item.cmd_write;
        o_wr_entry.size    = sat_size;
        o_wr_entry.data    = i_item.cmd_data & scrq_pkg::size_mask(sat_size);
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_sidx  = r_sidx;
        n_err   = r_err;
        o_wr_en = 1'b0;
        o_res   = '0;
        if (i_go) begin
            if (i_item.op == scrq_pkg::OP_ENQUEUE) begin
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    o_res.enqueue_refused = 1'b1;
                end else begin
                    o_wr_en = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (CW'(r_sidx) < r_count) begin
                    o_res.tx_control = {i_rd_send.write, i_rd_send.address};
                    o_res.tx_data    = i_rd_send.write ? i_rd_send.data : '0;
                end
                if (!fault) begin
                    if (r_count == '0) begin
                        n_sidx = '0;
                    end else if (r_sidx < scrq_pkg::LATENCY_TICKS) begin
                        n_sidx = r_sidx + 2'd1;
                    end else if (match && (ok || bad)) begin
                        o_res.done_valid   = 1'b1;
                        o_res.done_address = i_rd_head.address;
                        if (ok) begin
                            if (!i_rd_head.write) begin
                                o_res.done_read_data = i_item.rx_data
                                    & scrq_pkg::size_mask(i_rd_head.size);
                            end
                        end else begin
                            o_res.done_failed = 1'b1;
                        end
                        n_head  = head_next;
                        n_count = r_count - CW'(1);
                    end else begin
                        n_sidx = '0;
                    end
                    n_err = '0;
                end else begin
                    n_sidx = '0;
                    if (r_err != scrq_pkg::ERR_MAX) begin
                        n_err = r_err + 8'd1;
                    end
                end
                if (n_count == '0) begin
                    n_sidx           = '0;
                    o_res.tx_control = '0;
                    o_res.tx_data    = '0;
                end
            end
            o_res.queue_empty        = (n_count == '0);
            o_res.packet_error_count = n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_sidx  <= '0;
            r_err   <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_sidx  <= n_sidx;
            r_err   <= n_err;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_sidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sidx <= scrq_pkg::LATENCY_TICKS)
        else $error("send index beyond latency window");

    a_empty_sidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_sidx == '0)
        else $error("send index nonzero on empty queue");

    a_retire_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_res.done_valid) |=> r_count == $past(r_count) - CW'(1))
        else $error("retire did not drop entry count");

    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_res.enqueue_refused) |-> r_count == CW'(QUEUE_DEPTH))
        else $error("enqueue refused with room left");

endmodule
